// ----- sv/vdss_pkg.sv -----
// Shared types and constants of the vehicle drive state sequencer.
package vdss_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TORQUE_W = 7;
  localparam int unsigned MOTOR_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PRECHARGE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ENERGIZED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BUZZING   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DRIVE     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FAULT     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_OFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_DUR  = 2'd2;

  localparam logic [LEVEL_W-1:0]  BRAKE_ON_RST  = 12'd200;
  localparam logic [LEVEL_W-1:0]  BRAKE_OFF_RST = 12'd100;
  localparam logic [DUR_W-1:0]    BUZZ_DUR_RST  = 16'd2000;
  localparam logic [MOTOR_W-1:0]  ALL_MOTORS    = 4'hF;
  localparam logic [TORQUE_W-1:0] TORQUE_MAX    = 7'd100;

  typedef struct packed {
    logic [LEVEL_W-1:0] brake_on_level;
    logic [LEVEL_W-1:0] brake_off_level;
    logic [DUR_W-1:0]   buzz_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic               sdc_closed;
    logic               precharge_done;
    logic               start_pressed;
    logic               start_stale;
    logic [LEVEL_W-1:0] throttle_level;
    logic [LEVEL_W-1:0] brake_level;
    logic               throttle_brake_stale;
    logic [MOTOR_W-1:0] motors_running;
    logic [TIME_W-1:0]  time_ms;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]   current_mode;
    logic [MODE_W-1:0]   pending_mode;
    logic                brake_lamp;
    logic                buzzer_on;
    logic [TORQUE_W-1:0] torque_percent;
    logic                outputs_refreshed;
  } result_t;

endpackage

// ----- sv/vdss_cfg.sv -----
// Configuration register file of the drive state sequencer.
module vdss_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [vdss_pkg::CFG_IDX_W-1:0]      wr_idx,
  input  logic [vdss_pkg::CFG_DATA_W-1:0]     wr_data,
  output vdss_pkg::cfg_t                      cfg
);

  vdss_pkg::cfg_t cfg_r;
  vdss_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        vdss_pkg::CFG_BRAKE_ON:  cfg_nxt.brake_on_level  = wr_data[vdss_pkg::LEVEL_W-1:0];
        vdss_pkg::CFG_BRAKE_OFF: cfg_nxt.brake_off_level = wr_data[vdss_pkg::LEVEL_W-1:0];
        vdss_pkg::CFG_BUZZ_DUR:  cfg_nxt.buzz_duration_ms = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_on_level   <= vdss_pkg::BRAKE_ON_RST;
      cfg_r.brake_off_level  <= vdss_pkg::BRAKE_OFF_RST;
      cfg_r.buzz_duration_ms <= vdss_pkg::BUZZ_DUR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/vdss_core.sv -----
// Mode sequencing, brake lamp, buzzer timing and torque scaling for one tick.
module vdss_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  vdss_pkg::item_t  item,
  input  vdss_pkg::cfg_t   cfg,
  output vdss_pkg::result_t result
);

  logic [vdss_pkg::MODE_W-1:0]   pending_r, pending_nxt;
  logic                          lamp_r, lamp_nxt;
  logic                          buzzer_r, buzzer_nxt;
  logic [vdss_pkg::TIME_W-1:0]   buzz_start_r, buzz_start_nxt;
  logic [vdss_pkg::TORQUE_W-1:0] torque_r, torque_nxt;

  logic [vdss_pkg::MODE_W-1:0]   cur_mode;
  logic                          start;
  logic [vdss_pkg::TIME_W-1:0]   elapsed;
  logic                          buzz_done;
  logic [18:0]                   scaled;
  logic [6:0]                    quot_lo;
  logic [12:0]                   remain;
  logic [vdss_pkg::TORQUE_W-1:0] torque_calc;

  assign cur_mode  = pending_r;
  assign start     = item.start_pressed & ~item.start_stale;
  assign elapsed   = item.time_ms - buzz_start_r;
  assign buzz_done = elapsed >= {16'd0, cfg.buzz_duration_ms};

  // Divide by 4095 = 4096 - 1: the quotient estimate p >> 12 leaves a remainder of
  // (p mod 4096) + estimate, which stays below twice the divisor, so one correction suffices.
  assign scaled      = ({7'd0, item.throttle_level} << 6) + ({7'd0, item.throttle_level} << 5)
                     + ({7'd0, item.throttle_level} << 2);
  assign quot_lo     = scaled[18:12];
  assign remain      = {1'b0, scaled[11:0]} + {6'd0, quot_lo};
  assign torque_calc = (remain >= 13'd4095) ? quot_lo + 7'd1 : quot_lo;

  always_comb begin
    pending_nxt    = cur_mode;
    lamp_nxt       = lamp_r;
    buzzer_nxt     = buzzer_r;
    buzz_start_nxt = buzz_start_r;
    torque_nxt     = torque_r;
    if (!item.sdc_closed) begin
      pending_nxt = vdss_pkg::MODE_FAULT;
    end else begin
      if (item.brake_level > cfg.brake_on_level) begin
        lamp_nxt = 1'b1;
      end else if (item.brake_level < cfg.brake_off_level) begin
        lamp_nxt = 1'b0;
      end
      unique case (cur_mode)
        vdss_pkg::MODE_INIT: pending_nxt = vdss_pkg::MODE_IDLE;
        vdss_pkg::MODE_IDLE: pending_nxt = vdss_pkg::MODE_PRECHARGE;
        vdss_pkg::MODE_PRECHARGE: begin
          if (item.precharge_done) pending_nxt = vdss_pkg::MODE_ENERGIZED;
        end
        vdss_pkg::MODE_ENERGIZED: begin
          if (start && item.motors_running == vdss_pkg::ALL_MOTORS) begin
            buzz_start_nxt = item.time_ms;
            pending_nxt    = vdss_pkg::MODE_BUZZING;
          end
        end
        vdss_pkg::MODE_BUZZING: begin
          buzzer_nxt = ~buzz_done;
          if (buzz_done) pending_nxt = vdss_pkg::MODE_DRIVE;
        end
        vdss_pkg::MODE_DRIVE: begin
          torque_nxt = item.throttle_brake_stale ? '0 : torque_calc;
          if (start) pending_nxt = vdss_pkg::MODE_IDLE;
        end
        vdss_pkg::MODE_FAULT: pending_nxt = vdss_pkg::MODE_IDLE;
        default: pending_nxt = vdss_pkg::MODE_FAULT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= vdss_pkg::MODE_INIT;
      lamp_r       <= 1'b0;
      buzzer_r     <= 1'b0;
      buzz_start_r <= '0;
      torque_r     <= '0;
    end else if (fire) begin
      pending_r    <= pending_nxt;
      lamp_r       <= lamp_nxt;
      buzzer_r     <= buzzer_nxt;
      buzz_start_r <= buzz_start_nxt;
      torque_r     <= torque_nxt;
    end
  end

  always_comb begin
    result.current_mode      = cur_mode;
    result.pending_mode      = pending_nxt;
    result.brake_lamp        = lamp_nxt;
    result.buzzer_on         = buzzer_nxt;
    result.torque_percent    = torque_nxt;
    result.outputs_refreshed = item.sdc_closed;
  end

  a_fault_on_open: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.sdc_closed |=> pending_r == vdss_pkg::MODE_FAULT)
    else $error("open shutdown circuit did not select fault");

  a_torque_range: assert property (@(posedge clk) disable iff (!rst_n)
    torque_r <= vdss_pkg::TORQUE_MAX)
    else $error("torque request above full scale");

  a_torque_held: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !(item.sdc_closed && cur_mode == vdss_pkg::MODE_DRIVE) |=> $stable(torque_r))
    else $error("torque changed outside drive");

  a_drive_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == vdss_pkg::MODE_DRIVE |-> !buzzer_r)
    else $error("buzzer still on when drive is pending");

endmodule

// ----- sv/vehicle_drive_state_sequencer_top.sv -----
// Top level of the vehicle drive state sequencer: stream ports, input and result registers.
// The input register takes each accepted item; the result register and the mode, lamp, buzzer
// and torque state are loaded from it when the output side can take it (no out_tready stall).
// Throughput: one item per cycle while out_tready does not stall the result register.
// Reset (rst_n, synchronous, active low) returns the mode to init, clears lamp, buzzer,
// buzz start time and torque, restores the registers to their defaults and empties both stages.
module vehicle_drive_state_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sdc_closed, precharge_done, start_pressed, start_stale, throttle_level[11:0],
  // brake_level[11:0], throttle_brake_stale, motors_running[3:0], time_ms[31:0], zero fill
  input  logic [vdss_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_mode[2:0], pending_mode[2:0], brake_lamp, buzzer_on, torque_percent[6:0],
  // outputs_refreshed
  output logic [vdss_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vdss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vdss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                            in_valid_r;
  vdss_pkg::item_t                 item_r;
  vdss_pkg::item_t                 item_nxt;
  logic                            out_valid_r;
  logic [vdss_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [vdss_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic                            out_load;
  logic                            fire;
  logic                            in_take;
  vdss_pkg::cfg_t                  cfg;
  vdss_pkg::result_t               result;

  assign out_load  = ~out_valid_r | out_tready;
  assign fire      = in_valid_r & out_load;
  assign in_tready = ~in_valid_r | out_load;
  assign in_take   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    item_nxt.sdc_closed           = in_tdata[0];
    item_nxt.precharge_done       = in_tdata[1];
    item_nxt.start_pressed        = in_tdata[2];
    item_nxt.start_stale          = in_tdata[3];
    item_nxt.throttle_level       = in_tdata[15:4];
    item_nxt.brake_level          = in_tdata[27:16];
    item_nxt.throttle_brake_stale = in_tdata[28];
    item_nxt.motors_running       = in_tdata[32:29];
    item_nxt.time_ms              = in_tdata[64:33];
  end

  assign out_data_nxt = {result.outputs_refreshed, result.torque_percent, result.buzzer_on,
                         result.brake_lamp, result.pending_mode, result.current_mode};

  vdss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  vdss_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (out_load)  out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= item_nxt;
    if (fire)    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- test/tb_vehicle_drive_state_sequencer_top.sv -----
// Self-checking testbench for the vehicle drive state sequencer with its own tick predictor.
`timescale 1ns / 1ps

module tb_vehicle_drive_state_sequencer_top;

  typedef logic [vdss_pkg::LEVEL_W-1:0]    level_t;
  typedef logic [vdss_pkg::MOTOR_W-1:0]    motors_t;
  typedef logic [vdss_pkg::TIME_W-1:0]     ms_t;
  typedef logic [vdss_pkg::TORQUE_W-1:0]   torque_t;
  typedef logic [vdss_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam int unsigned LIMIT_CYCLES   = 200000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_TICKS   = 175;
  localparam int unsigned THROTTLE_FULL  = 4095;
  localparam int unsigned LEVEL_MAX      = 4095;
  localparam logic [vdss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [vdss_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [vdss_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [vdss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vdss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the sequencer state.
  level_t                      lamp_on_lvl  = vdss_pkg::BRAKE_ON_RST;
  level_t                      lamp_off_lvl = vdss_pkg::BRAKE_OFF_RST;
  logic [vdss_pkg::DUR_W-1:0]  buzz_ms      = vdss_pkg::BUZZ_DUR_RST;
  logic [vdss_pkg::MODE_W-1:0] mode_cur     = vdss_pkg::MODE_INIT;
  logic [vdss_pkg::MODE_W-1:0] mode_pend    = vdss_pkg::MODE_INIT;
  logic                        lamp_q       = 1'b0;
  logic                        buzzer_q     = 1'b0;
  ms_t                         buzz_t0      = '0;
  torque_t                     torque_q     = '0;

  vdss_pkg::result_t tick_results_q[$];
  vdss_pkg::result_t seen_res;
  vdss_pkg::result_t want_res;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 38;
  int unsigned rx_idle_pct = 63;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  ms_t         ms_now = '0;

  typedef struct {
    bit                          sdc;
    bit                          pre;
    bit                          press;
    bit                          stale;
    level_t                      thr;
    level_t                      brk;
    bit                          tbs;
    motors_t                     mot;
    ms_t                         ms;
    bit                          chk;
    logic [vdss_pkg::MODE_W-1:0] cur;
    logic [vdss_pkg::MODE_W-1:0] nxt;
    bit                          lamp;
    bit                          buz;
    torque_t                     tq;
    bit                          rfr;
  } tick_row_t;

  // Walk from reset through every mode, with threshold edges, the buzz timer across the
  // time wrap, a shutdown while buzzing and the torque extremes.
  tick_row_t directed_ticks [25] = '{
    '{1, 0, 0, 0, 4095,    0, 0, 4'h0, 32'd0,         1,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_IDLE,  1'b0, 1'b0, 7'd0, 1'b1},
    '{0, 1, 1, 0, 4095, 4095, 1, 4'hF, 32'hFFFF_FFFF, 1,
      vdss_pkg::MODE_IDLE,  vdss_pkg::MODE_FAULT, 1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0, 4095, 0, 4'h0, 32'd10,        1,
      vdss_pkg::MODE_FAULT, vdss_pkg::MODE_IDLE,  1'b1, 1'b0, 7'd0, 1'b1},
    '{1, 0, 0, 0,    0,  150, 0, 4'h0, 32'd20,        0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  200, 0, 4'h0, 32'd30,        0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 1, 0, 0,    0,   99, 0, 4'h0, 32'd40,        0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 1,    0,  100, 0, 4'hF, 32'd50,        0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 0,    0,  100, 0, 4'h7, 32'd60,        0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 0,    0,  100, 0, 4'hF, 32'hFFFF_FF00, 0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  201, 0, 4'hF, 32'h0000_0100, 0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{0, 0, 0, 0,    0,  201, 0, 4'hF, 32'h0000_0200, 0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  201, 0, 4'hF, 32'h0000_0300, 0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  201, 0, 4'hF, 32'd4000,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 1, 0, 0,    0,  201, 0, 4'hF, 32'd4500,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 0,    0,  201, 0, 4'hF, 32'd5000,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  201, 0, 4'hF, 32'd6999,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,  201, 0, 4'hF, 32'd7000,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0, 4095,   50, 0, 4'hF, 32'd7010,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,   41,   50, 0, 4'hF, 32'd7020,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,   40,   50, 0, 4'hF, 32'd7030,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0, 4095,   50, 1, 4'hF, 32'd7040,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 1, 2048,   50, 0, 4'hF, 32'd7050,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 1, 0, 4095,   50, 0, 4'hF, 32'd7060,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{1, 0, 0, 0,    0,   50, 0, 4'hF, 32'd7070,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0},
    '{0, 0, 0, 0,    0, 4095, 0, 4'hF, 32'd7080,      0,
      vdss_pkg::MODE_INIT,  vdss_pkg::MODE_INIT,  1'b0, 1'b0, 7'd0, 1'b0}
  };

  vehicle_drive_state_sequencer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [vdss_pkg::IN_DATA_W-1:0] pack_tick(vdss_pkg::item_t it);
    return {7'b0, it.time_ms, it.motors_running, it.throttle_brake_stale, it.brake_level,
            it.throttle_level, it.start_stale, it.start_pressed, it.precharge_done,
            it.sdc_closed};
  endfunction

  // One periodic tick of the sequencer; updates the predictor state.
  function automatic vdss_pkg::result_t predict_tick(vdss_pkg::item_t it);
    vdss_pkg::result_t r;
    logic              go;
    ms_t               elapsed;
    go = it.start_pressed && !it.start_stale;
    mode_cur = mode_pend;
    mode_pend = mode_cur;
    if (!it.sdc_closed) begin
      mode_pend = vdss_pkg::MODE_FAULT;
    end else begin
      // The on test wins where the thresholds overlap.
      if (it.brake_level > lamp_on_lvl) lamp_q = 1'b1;
      else if (it.brake_level < lamp_off_lvl) lamp_q = 1'b0;
      case (mode_cur)
        vdss_pkg::MODE_INIT: mode_pend = vdss_pkg::MODE_IDLE;
        vdss_pkg::MODE_IDLE: mode_pend = vdss_pkg::MODE_PRECHARGE;
        vdss_pkg::MODE_PRECHARGE: begin
          if (it.precharge_done) mode_pend = vdss_pkg::MODE_ENERGIZED;
        end
        vdss_pkg::MODE_ENERGIZED: begin
          if (go && it.motors_running == vdss_pkg::ALL_MOTORS) begin
            buzz_t0 = it.time_ms;
            mode_pend = vdss_pkg::MODE_BUZZING;
          end
        end
        vdss_pkg::MODE_BUZZING: begin
          buzzer_q = 1'b1;
          elapsed = it.time_ms - buzz_t0;
          if (elapsed >= ms_t'(buzz_ms)) begin
            buzzer_q = 1'b0;
            mode_pend = vdss_pkg::MODE_DRIVE;
          end
        end
        vdss_pkg::MODE_DRIVE: begin
          if (it.throttle_brake_stale) torque_q = '0;
          else torque_q = torque_t'((32'(it.throttle_level) * 32'(vdss_pkg::TORQUE_MAX))
                                    / THROTTLE_FULL);
          if (go) mode_pend = vdss_pkg::MODE_IDLE;
        end
        vdss_pkg::MODE_FAULT: mode_pend = vdss_pkg::MODE_IDLE;
        default: mode_pend = vdss_pkg::MODE_FAULT;
      endcase
    end
    r.current_mode      = mode_cur;
    r.pending_mode      = mode_pend;
    r.brake_lamp        = lamp_q;
    r.buzzer_on         = buzzer_q;
    r.torque_percent    = torque_q;
    r.outputs_refreshed = it.sdc_closed;
    return r;
  endfunction

  // Mostly healthy ticks with a clock that runs on, brake readings near the thresholds,
  // and now and then a jump of the clock, often to just before the wrap.
  function automatic vdss_pkg::item_t random_tick();
    vdss_pkg::item_t it;
    int              brk;
    int              pick;
    it.sdc_closed           = ($urandom_range(0, 99) < 94);
    it.precharge_done       = ($urandom_range(0, 1) == 1);
    it.start_pressed        = ($urandom_range(0, 99) < 30);
    it.start_stale          = ($urandom_range(0, 99) < 25);
    it.throttle_brake_stale = ($urandom_range(0, 99) < 15);
    it.motors_running       = ($urandom_range(0, 99) < 75) ? vdss_pkg::ALL_MOTORS
                                                           : motors_t'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.throttle_level = '0;
    else if (pick == 1) it.throttle_level = level_t'(LEVEL_MAX);
    else it.throttle_level = level_t'($urandom_range(0, LEVEL_MAX));
    if ($urandom_range(0, 99) < 40) begin
      brk = $urandom_range(0, LEVEL_MAX);
    end else begin
      brk = $urandom_range(0, 1) ? int'(lamp_on_lvl) : int'(lamp_off_lvl);
      brk = brk + int'($urandom_range(0, 4)) - 2;
      if (brk < 0) brk = 0;
      if (brk > int'(LEVEL_MAX)) brk = LEVEL_MAX;
    end
    it.brake_level = level_t'(brk);
    pick = $urandom_range(0, 99);
    if (pick < 5) ms_now = $urandom();
    else if (pick < 8) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else ms_now = ms_now + $urandom_range(0, int'(buzz_ms) / 2 + 20);
    it.time_ms = ms_now;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_tick(input vdss_pkg::item_t it, input bit typed,
                           input vdss_pkg::result_t typed_res);
    vdss_pkg::result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_tick(it);
    do @(posedge clk); while (!in_tready);
    r = predict_tick(it);
    tick_results_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input logic [vdss_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vdss_pkg::CFG_BRAKE_ON:  lamp_on_lvl  = val[vdss_pkg::LEVEL_W-1:0];
      vdss_pkg::CFG_BRAKE_OFF: lamp_off_lvl = val[vdss_pkg::LEVEL_W-1:0];
      vdss_pkg::CFG_BUZZ_DUR:  buzz_ms      = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off that lets the block fill up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res.current_mode      = out_tdata[2:0];
      seen_res.pending_mode      = out_tdata[5:3];
      seen_res.brake_lamp        = out_tdata[6];
      seen_res.buzzer_on         = out_tdata[7];
      seen_res.torque_percent    = out_tdata[14:8];
      seen_res.outputs_refreshed = out_tdata[15];
      if (tick_results_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_tdata), 0);
      end else begin
        want_res = tick_results_q.pop_front();
        if (seen_res.current_mode != want_res.current_mode)
          report_mismatch("current_mode", seen_res.current_mode, want_res.current_mode);
        if (seen_res.pending_mode != want_res.pending_mode)
          report_mismatch("pending_mode", seen_res.pending_mode, want_res.pending_mode);
        if (seen_res.brake_lamp != want_res.brake_lamp)
          report_mismatch("brake_lamp", seen_res.brake_lamp, want_res.brake_lamp);
        if (seen_res.buzzer_on != want_res.buzzer_on)
          report_mismatch("buzzer_on", seen_res.buzzer_on, want_res.buzzer_on);
        if (seen_res.torque_percent != want_res.torque_percent)
          report_mismatch("torque_percent", seen_res.torque_percent, want_res.torque_percent);
        if (seen_res.outputs_refreshed != want_res.outputs_refreshed)
          report_mismatch("outputs_refreshed", seen_res.outputs_refreshed,
                          want_res.outputs_refreshed);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    vdss_pkg::item_t   it;
    vdss_pkg::result_t typed_res;
    level_t            on_pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_ticks[i]) begin
      it.sdc_closed           = directed_ticks[i].sdc;
      it.precharge_done       = directed_ticks[i].pre;
      it.start_pressed        = directed_ticks[i].press;
      it.start_stale          = directed_ticks[i].stale;
      it.throttle_level       = directed_ticks[i].thr;
      it.brake_level          = directed_ticks[i].brk;
      it.throttle_brake_stale = directed_ticks[i].tbs;
      it.motors_running       = directed_ticks[i].mot;
      it.time_ms              = directed_ticks[i].ms;
      typed_res.current_mode      = directed_ticks[i].cur;
      typed_res.pending_mode      = directed_ticks[i].nxt;
      typed_res.brake_lamp        = directed_ticks[i].lamp;
      typed_res.buzzer_on         = directed_ticks[i].buz;
      typed_res.torque_percent    = directed_ticks[i].tq;
      typed_res.outputs_refreshed = directed_ticks[i].rfr;
      send_tick(it, directed_ticks[i].chk, typed_res);
    end
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          // Lowest thresholds (upper data bits must be dropped) and no buzz time at all.
          write_reg(vdss_pkg::CFG_BRAKE_ON, 16'hF000);
          write_reg(vdss_pkg::CFG_BRAKE_OFF, 16'h0000);
          write_reg(vdss_pkg::CFG_BUZZ_DUR, 16'h0000);
        end
        1: begin
          tx_idle_pct = 63;
          rx_idle_pct = 38;
          write_reg(vdss_pkg::CFG_BRAKE_ON, 16'h0FFF);
          write_reg(vdss_pkg::CFG_BRAKE_OFF, 16'hFFFF);
          write_reg(vdss_pkg::CFG_BUZZ_DUR, 16'hFFFF);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          on_pick = level_t'($urandom_range(500, 2000));
          write_reg(CFG_UNUSED_IDX, cfg_word_t'($urandom_range(0, 65535)));
          write_reg(vdss_pkg::CFG_BRAKE_ON, cfg_word_t'(on_pick));
          // Off level above the on level, so the two tests overlap.
          write_reg(vdss_pkg::CFG_BRAKE_OFF,
                    cfg_word_t'(32'(on_pick) + $urandom_range(1, 1000)));
          write_reg(vdss_pkg::CFG_BUZZ_DUR, cfg_word_t'($urandom_range(1, 3000)));
          hold_req = 1'b1;
        end
      endcase
      ms_now = $urandom();
      for (int n = 0; n < RANDOM_TICKS; n++) send_tick(random_tick(), 1'b0, typed_res);
      drain_results();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/vdss_pkg.sv
sv/vdss_cfg.sv
sv/vdss_core.sv
sv/vehicle_drive_state_sequencer_top.sv
test/tb_vehicle_drive_state_sequencer_top.sv
